FILE: src/btf_pkg.sv
// Shared constants, codes and the close record for the binned threshold fraction block.
// No dependencies; every other file in src but btf_ram imports this package.
package btf_pkg;

  // Bin storage: one edge more than the number of bins.
  localparam int unsigned MAX_BINS   = 16;
  localparam int unsigned EDGE_DEPTH = MAX_BINS + 1;
  localparam int unsigned EDGE_AW    = $clog2(EDGE_DEPTH);

  // Field widths.
  localparam int unsigned EDGE_W     = 32;
  localparam int unsigned DT_W       = 32;
  localparam int unsigned DM_W       = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned BINS_W     = 7;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned BIN_W      = 6;
  localparam int unsigned CNT_W      = 20;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Depth of the queue between the sequencer and the divider.
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
  localparam logic [BINS_W-1:0] BINS_RESET = BINS_W'(16);
  localparam logic [BINS_W-1:0] BINS_LIMIT = BINS_W'(MAX_BINS);
  localparam logic [IDX_W-1:0]  IDX_LIMIT  = IDX_W'(MAX_BINS);

  // Item modes.
  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_PAIR = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 1'b1;

  // One closed bin on its way to the divider.
  typedef struct packed {
    logic [BIN_W-1:0] bin_index;
    logic [CNT_W-1:0] pair_count;
    logic [CNT_W-1:0] high_count;
    logic             run_last;
  } btf_close_t;

endpackage

FILE: src/binned_threshold_fraction.sv
// Top level of the binned threshold fraction block: sequencer, queue and divider.
// Depends on btf_pkg, btf_front, btf_queue and btf_back.
//
//   Channel   Signals                          Direction   Transfer when
//   ------    -------------------------------  ---------   --------------------------
//   cfg       cfg_we_i, cfg_index_i, _wdata_i  in          cfg_we_i high
//   in        in_valid_i / in_ready_o + fields in          in_valid_i && in_ready_o
//   out       out_valid_o / out_ready_i + flds out         out_valid_o && out_ready_i
//
// An edge write is taken in the idle state. A pair passes the sequencer states check,
// compare and tail when it stays in its bin and check and tail when it is skipped,
// plus a check and a compare per bin that it passes (one edge-RAM read each), a tail
// step per bin that a last pair flushes, and a flush step to queue the final bin.
// Each closed bin passes through the divider (17 quotient bits, one per cycle),
// which runs behind a 4-entry queue so the sequencer stalls only when that queue fills.
// Reset is asynchronous and active low; the edge table holds no reset value and must be
// written before pairs arrive. A stalled output holds the finished result in its register.
module binned_threshold_fraction import btf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  mode_i,
  input  logic [IDX_W-1:0]      edge_index_i,
  input  logic [EDGE_W-1:0]     edge_value_i,
  input  logic [DT_W-1:0]       delta_t_i,
  input  logic [DM_W-1:0]       delta_m_i,
  input  logic                  last_pair_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [BIN_W-1:0]      bin_index_o,
  output logic [CNT_W-1:0]      pair_count_o,
  output logic [CNT_W-1:0]      high_count_o,
  output logic [FRAC_W-1:0]     fraction_o,
  output logic                  bin_empty_o,
  output logic                  run_last_o
);

  logic       push;
  btf_close_t push_data;
  logic       push_ready;
  logic       pop_valid;
  logic       pop_ready;
  btf_close_t pop_data;

  // Sequencer: accepts items and closes bins.
  btf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .edge_index_i (edge_index_i),
    .edge_value_i (edge_value_i),
    .delta_t_i    (delta_t_i),
    .delta_m_i    (delta_m_i),
    .last_pair_i  (last_pair_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .q_ready_i    (push_ready)
  );

  // Queue of closed bins.
  btf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Divider and result register.
  btf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (pop_valid),
    .q_data_i     (pop_data),
    .q_pop_o      (pop_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .bin_index_o  (bin_index_o),
    .pair_count_o (pair_count_o),
    .high_count_o (high_count_o),
    .fraction_o   (fraction_o),
    .bin_empty_o  (bin_empty_o),
    .run_last_o   (run_last_o)
  );

  // An empty bin reports a zero fraction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bin_empty_o |-> fraction_o == '0)
    else $error("empty bin with nonzero fraction");

  // High pairs are a subset of the bin's pairs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> high_count_o <= pair_count_o)
    else $error("high count exceeds pair count");

  // The fraction never exceeds one in Q1.16.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fraction_o <= FRAC_W'(65536))
    else $error("fraction above one");

  // The sequencer never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> push_ready)
    else $error("push into full queue");

endmodule

FILE: src/btf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module btf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 17,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/btf_front.sv
// Front part: configuration registers, edge table, bin sequencer and counters.
// Depends on btf_pkg and btf_ram; emits closed bins toward btf_queue.
module btf_front import btf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  mode_i,
  input  logic [IDX_W-1:0]      edge_index_i,
  input  logic [EDGE_W-1:0]     edge_value_i,
  input  logic [DT_W-1:0]       delta_t_i,
  input  logic [DM_W-1:0]       delta_m_i,
  input  logic                  last_pair_i,
  output logic                  push_o,
  output btf_close_t            push_data_o,
  input  logic                  q_ready_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CMP,
    S_TAIL,
    S_FLUSH
  } state_e;

  state_e            state_q, state_d;
  logic [THR_W-1:0]  thr_q;
  logic [BINS_W-1:0] bins_q;
  logic [EDGE_W-1:0] edge0_q, edge0_d;
  logic [BIN_W-1:0]  cur_q, cur_d;
  logic [CNT_W-1:0]  pairs_q, pairs_d;
  logic [CNT_W-1:0]  highs_q, highs_d;
  logic              done_q, done_d;
  logic [DT_W-1:0]   dt_q, dt_d;
  logic [DM_W-1:0]   dm_q, dm_d;
  logic              last_q, last_d;
  logic              pend_valid_q, pend_valid_d;
  btf_close_t        pend_q, pend_d;

  logic [BINS_W-1:0]  n_bins;
  logic [BINS_W-1:0]  cur_ext;
  logic [BIN_W-1:0]   cur_inc;
  logic               ram_we;
  logic [EDGE_AW-1:0] ram_raddr;
  logic [EDGE_W-1:0]  ram_rdata;
  logic               can_close;
  logic               cur_below_n;

  // Number of bins in use, clamped to the supported range.
  always_comb begin
    if (bins_q == '0) begin
      n_bins = BINS_W'(1);
    end else if (bins_q > BINS_LIMIT) begin
      n_bins = BINS_LIMIT;
    end else begin
      n_bins = bins_q;
    end
  end

  assign cur_ext     = {1'b0, cur_q};
  assign cur_inc     = cur_q + BIN_W'(1);
  assign cur_below_n = cur_ext < n_bins;

  // The upper edge of the current bin is read every cycle.
  assign ram_raddr = EDGE_AW'(cur_inc);

  btf_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (EDGE_DEPTH)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (EDGE_AW'(edge_index_i)),
    .wdata_i (edge_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A close needs room for the previously closed bin, which moves on to the queue.
  assign can_close  = !pend_valid_q || q_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer next-state logic.
  always_comb begin
    state_d      = state_q;
    edge0_d      = edge0_q;
    cur_d        = cur_q;
    pairs_d      = pairs_q;
    highs_d      = highs_q;
    done_d       = done_q;
    dt_d         = dt_q;
    dm_d         = dm_q;
    last_d       = last_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    ram_we       = 1'b0;
    push_o       = 1'b0;
    push_data_o  = pend_q;
    push_data_o.run_last = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == MODE_EDGE) begin
            // Out-of-range edge writes are dropped.
            if (edge_index_i <= IDX_LIMIT) begin
              ram_we = 1'b1;
              if (edge_index_i == '0) begin
                edge0_d = edge_value_i;
              end
            end
          end else begin
            dt_d    = delta_t_i;
            dm_d    = delta_m_i;
            last_d  = last_pair_i;
            state_d = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        if (!cur_below_n) begin
          done_d  = 1'b1;
          state_d = S_TAIL;
        end else if (done_q || dt_q < edge0_q) begin
          state_d = S_TAIL;
        end else begin
          state_d = S_CMP;
        end
      end

      S_CMP: begin
        if (dt_q >= ram_rdata) begin
          // The pair lies past this bin: close it and look at the next one.
          if (can_close) begin
            push_o       = pend_valid_q;
            pend_d       = '{bin_index: cur_q, pair_count: pairs_q,
                             high_count: highs_q, run_last: 1'b0};
            pend_valid_d = 1'b1;
            cur_d        = cur_inc;
            pairs_d      = '0;
            highs_d      = '0;
            state_d      = S_CHECK;
          end
        end else begin
          // The pair falls in this bin; counts saturate.
          if (pairs_q != CNT_MAX) begin
            pairs_d = pairs_q + CNT_W'(1);
          end
          if (dm_q > thr_q && highs_q != CNT_MAX) begin
            highs_d = highs_q + CNT_W'(1);
          end
          state_d = S_TAIL;
        end
      end

      S_TAIL: begin
        if (last_q && !done_q && cur_below_n) begin
          // End of data set: close the remaining bins one per cycle while the queue has room.
          if (can_close) begin
            push_o       = pend_valid_q;
            pend_d       = '{bin_index: cur_q, pair_count: pairs_q,
                             high_count: highs_q, run_last: 1'b0};
            pend_valid_d = 1'b1;
            cur_d        = cur_inc;
            pairs_d      = '0;
            highs_d      = '0;
          end
        end else begin
          if (last_q) begin
            cur_d   = '0;
            pairs_d = '0;
            highs_d = '0;
            done_d  = 1'b0;
          end
          state_d = pend_valid_q ? S_FLUSH : S_IDLE;
        end
      end

      S_FLUSH: begin
        // The held bin is the final result of this item.
        if (q_ready_i) begin
          push_o               = 1'b1;
          push_data_o.run_last = 1'b1;
          pend_valid_d         = 1'b0;
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, configuration and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      thr_q        <= '0;
      bins_q       <= BINS_RESET;
      edge0_q      <= '0;
      cur_q        <= '0;
      pairs_q      <= '0;
      highs_q      <= '0;
      done_q       <= 1'b0;
      dt_q         <= '0;
      dm_q         <= '0;
      last_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
    end else begin
      state_q      <= state_d;
      edge0_q      <= edge0_d;
      cur_q        <= cur_d;
      pairs_q      <= pairs_d;
      highs_q      <= highs_d;
      done_q       <= done_d;
      dt_q         <= dt_d;
      dm_q         <= dm_d;
      last_q       <= last_d;
      pend_valid_q <= pend_valid_d;
      pend_q       <= pend_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_THRESHOLD:   thr_q  <= cfg_wdata_i[THR_W-1:0];
          REG_BINS_IN_USE: bins_q <= cfg_wdata_i[BINS_W-1:0];
          default:         thr_q  <= thr_q;
        endcase
      end
    end
  end

endmodule

FILE: src/btf_queue.sv
// Small FIFO of closed bins between the sequencer and the divider.
// Depends on btf_pkg.
module btf_queue import btf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  btf_close_t push_data_i,
  output logic       push_ready_o,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output btf_close_t pop_data_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  btf_close_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNT_QW-1:0]   count_q;
  logic                do_push, do_pop;

  assign push_ready_o = count_q != CNT_QW'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = entries[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_QW'(1);
      end
    end
  end

endmodule

FILE: src/btf_back.sv
// Back part: bit-serial divider for the Q1.16 fraction and the result register.
// Depends on btf_pkg; takes closed bins from btf_queue.
module btf_back import btf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  btf_close_t        q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BIN_W-1:0]  bin_index_o,
  output logic [CNT_W-1:0]  pair_count_o,
  output logic [CNT_W-1:0]  high_count_o,
  output logic [FRAC_W-1:0] fraction_o,
  output logic              bin_empty_o,
  output logic              run_last_o
);

  localparam int unsigned NUM_W  = CNT_W + FRAC_W + 1;
  localparam int unsigned REM_W  = CNT_W + 1;
  localparam int unsigned STEP_W = $clog2(FRAC_W);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } state_e;

  state_e            state_q;
  btf_close_t        rec_q;
  logic [REM_W-1:0]  rem_q;
  logic [FRAC_W-1:0] quo_q;
  logic [REM_W-1:0]  dsr_q;
  logic [STEP_W-1:0] step_q;

  logic [NUM_W-1:0]  num;
  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;
  logic              ge;
  logic              empty;
  logic              load_out;

  // Numerator high_count * 2^17 + pair_count; the divisor is 2 * pair_count,
  // which rounds the quotient to nearest with halves up.
  assign num = {1'b0, q_data_i.high_count, {FRAC_W{1'b0}}} + NUM_W'(q_data_i.pair_count);

  // One restoring division step per cycle.
  assign trial = {rem_q, quo_q[FRAC_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};
  assign empty = rec_q.pair_count == '0;

  assign q_pop_o = (state_q == B_IDLE) && q_valid_i;

  // A finished result enters the output register once the previous one has been taken.
  assign load_out = (state_q == B_DONE) && (!out_valid_o || out_ready_i);

  // Divider sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      rec_q        <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      dsr_q        <= '0;
      step_q       <= '0;
      out_valid_o  <= 1'b0;
      bin_index_o  <= '0;
      pair_count_o <= '0;
      high_count_o <= '0;
      fraction_o   <= '0;
      bin_empty_o  <= 1'b0;
      run_last_o   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (q_valid_i) begin
            rec_q   <= q_data_i;
            rem_q   <= num[NUM_W-1:FRAC_W];
            quo_q   <= num[FRAC_W-1:0];
            dsr_q   <= {q_data_i.pair_count, 1'b0};
            step_q  <= STEP_W'(FRAC_W - 1);
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
          quo_q <= {quo_q[FRAC_W-2:0], ge};
          if (step_q == '0) begin
            state_q <= B_DONE;
          end else begin
            step_q <= step_q - STEP_W'(1);
          end
        end
        B_DONE: begin
          // Load the result fields together with the valid flag above.
          if (load_out) begin
            bin_index_o  <= rec_q.bin_index;
            pair_count_o <= rec_q.pair_count;
            high_count_o <= rec_q.high_count;
            fraction_o   <= empty ? '0 : quo_q;
            bin_empty_o  <= empty;
            run_last_o   <= rec_q.run_last;
            state_q      <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule
